FILE: rtl/asa_pkg.sv
// Package for the arrive steering accelerator: datapath widths and shared types.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps

package asa_pkg;

  // Q15.8 field width and derived widths
  localparam int DATA_W = 24;
  localparam int DIFF_W = DATA_W + 1;        // exact offset / velocity difference
  localparam int RAD_W  = DATA_W - 1;        // unsigned radii and speed
  localparam int RT_W   = 16;                // reach time, Q8.8
  localparam int SQ_W   = 2 * DIFF_W;        // dx*dx + dy*dy
  localparam int ROOT_W = DIFF_W;            // floor sqrt of SQ_W bits
  localparam int DIV_W  = DIFF_W;            // divider remainder/quotient width
  localparam int PROD_W = RAD_W + DIFF_W;    // speed * length products
  localparam int ACC_W  = DIFF_W + 8;        // |diff| * 256 + rounding

  typedef logic [DIV_W-1:0] div_word_t;

endpackage

FILE: rtl/asa_sqrt.sv
// Pipelined restoring integer square root, one root bit per stage.
// Depends on asa_pkg for widths.
`timescale 1ns / 1ps

module asa_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [asa_pkg::SQ_W-1:0]    rad_i,
  output logic [asa_pkg::ROOT_W-1:0]  root_o
);

  localparam int N     = asa_pkg::ROOT_W;
  localparam int REM_W = asa_pkg::ROOT_W + 1;
  localparam int T_W   = asa_pkg::ROOT_W + 3;

  logic [asa_pkg::SQ_W-1:0]   val_q [N];
  logic [asa_pkg::SQ_W-1:0]   val_d [N];
  logic [REM_W-1:0]           rem_q [N];
  logic [REM_W-1:0]           rem_d [N];
  logic [asa_pkg::ROOT_W-1:0] root_q[N];
  logic [asa_pkg::ROOT_W-1:0] root_d[N];
  logic [asa_pkg::SQ_W-1:0]   val_w [N];
  logic [REM_W-1:0]           rem_w [N];
  logic [asa_pkg::ROOT_W-1:0] root_w[N];
  logic [T_W-1:0]             cur_w [N];
  logic [T_W-1:0]             trial_w[N];
  logic [T_W-1:0]             sub_w [N];

  // one bit pair of the radicand per stage
  always_comb begin
    for (int k = 0; k < N; k++) begin
      val_w[k]   = (k == 0) ? rad_i : val_q[(k == 0) ? 0 : k - 1];
      rem_w[k]   = (k == 0) ? '0 : rem_q[(k == 0) ? 0 : k - 1];
      root_w[k]  = (k == 0) ? '0 : root_q[(k == 0) ? 0 : k - 1];
      cur_w[k]   = {rem_w[k], val_w[k][asa_pkg::SQ_W-1 -: 2]};
      trial_w[k] = {1'b0, root_w[k], 2'b01};
      sub_w[k]   = cur_w[k] - trial_w[k];
      val_d[k]   = val_w[k] << 2;
      if (cur_w[k] >= trial_w[k]) begin
        rem_d[k]  = sub_w[k][REM_W-1:0];
        root_d[k] = {root_w[k][asa_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = cur_w[k][REM_W-1:0];
        root_d[k] = {root_w[k][asa_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        val_q[k]  <= val_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

FILE: rtl/asa_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// The starting remainder must be below the divisor. Depends on asa_pkg.
`timescale 1ns / 1ps

module asa_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  asa_pkg::div_word_t rem_i,
  input  asa_pkg::div_word_t num_i,
  input  asa_pkg::div_word_t den_i,
  output asa_pkg::div_word_t quo_o
);

  localparam int N = asa_pkg::DIV_W;

  asa_pkg::div_word_t rem_q[N], rem_d[N];
  asa_pkg::div_word_t num_q[N], num_d[N];
  asa_pkg::div_word_t den_q[N], den_d[N];
  asa_pkg::div_word_t quo_q[N], quo_d[N];
  asa_pkg::div_word_t rem_w[N], num_w[N], den_w[N], quo_w[N];
  logic [N:0]         cur_w[N];
  logic [N:0]         sub_w[N];
  logic               ge_w [N];

  // shift in one numerator bit, subtract when it fits
  always_comb begin
    for (int k = 0; k < N; k++) begin
      rem_w[k] = (k == 0) ? rem_i : rem_q[(k == 0) ? 0 : k - 1];
      num_w[k] = (k == 0) ? num_i : num_q[(k == 0) ? 0 : k - 1];
      den_w[k] = (k == 0) ? den_i : den_q[(k == 0) ? 0 : k - 1];
      quo_w[k] = (k == 0) ? '0 : quo_q[(k == 0) ? 0 : k - 1];
      cur_w[k] = {rem_w[k], num_w[k][N-1]};
      sub_w[k] = cur_w[k] - {1'b0, den_w[k]};
      ge_w[k]  = cur_w[k] >= {1'b0, den_w[k]};
      rem_d[k] = ge_w[k] ? sub_w[k][N-1:0] : cur_w[k][N-1:0];
      num_d[k] = num_w[k] << 1;
      den_d[k] = den_w[k];
      quo_d[k] = {quo_w[k][N-2:0], ge_w[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k] <= rem_d[k];
        num_q[k] <= num_d[k];
        den_q[k] <= den_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[N-1];

endmodule

FILE: rtl/arrive_steering_accel.sv
// Arrive steering accelerator: one item per cycle sustained while the result is not stalled;
// the pipeline depth is set by the 25-stage square root and the three 25-stage dividers
// (speed, goal velocity, acceleration) in series.
// A stalled result holds the whole pipeline. Reset clears valid bits and loads the
// default register values (arrival 5.0, slowdown 100.0, top speed 50.0, reach 1.0).
// Uses asa_pkg, asa_sqrt and asa_div.
`timescale 1ns / 1ps

module arrive_steering_accel (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [asa_pkg::DATA_W-1:0] char_pos_x_i,
  input  logic signed [asa_pkg::DATA_W-1:0] char_pos_y_i,
  input  logic signed [asa_pkg::DATA_W-1:0] char_vel_x_i,
  input  logic signed [asa_pkg::DATA_W-1:0] char_vel_y_i,
  input  logic signed [asa_pkg::DATA_W-1:0] goal_pos_x_i,
  input  logic signed [asa_pkg::DATA_W-1:0] goal_pos_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [asa_pkg::DATA_W-1:0] accel_x_o,
  output logic signed [asa_pkg::DATA_W-1:0] accel_y_o,
  output logic                              saturated_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int DW     = asa_pkg::DATA_W;
  localparam int XW     = asa_pkg::DIFF_W;
  localparam int RW     = asa_pkg::RAD_W;
  localparam int QW     = asa_pkg::DIV_W;
  localparam int PW     = asa_pkg::PROD_W;
  localparam int AW     = asa_pkg::ACC_W;
  localparam int TW     = asa_pkg::RT_W;

  // stage indexes
  localparam int ST_IN   = 0;
  localparam int ST_SQR  = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_SPD  = ST_SUM + 1 + asa_pkg::ROOT_W;
  localparam int ST_GOAL = ST_SPD + 1 + QW;
  localparam int ST_ACC  = ST_GOAL + 1 + QW;
  localparam int ST_OUT  = ST_ACC + 1 + QW;

  localparam logic [QW-1:0] POS_MAX = QW'((1 << (DW - 1)) - 1);
  localparam logic [QW-1:0] NEG_MAX = QW'(1 << (DW - 1));

  typedef enum logic [1:0] {
    SPD_ZERO,
    SPD_TOP,
    SPD_DIV
  } spd_sel_e;

  typedef enum logic [1:0] {
    REG_ARRIVAL,
    REG_SLOWDOWN,
    REG_TOP,
    REG_REACH
  } cfg_reg_e;

  typedef struct packed {
    logic signed [XW-1:0]  dx;
    logic signed [XW-1:0]  dy;
    logic signed [DW-1:0]  vx;
    logic signed [DW-1:0]  vy;
    logic [asa_pkg::ROOT_W-1:0] dlen;
    spd_sel_e              sel;
    logic                  neg_x;
    logic                  neg_y;
    logic                  zero_x;
    logic                  zero_y;
    logic                  ovf_x;
    logic                  ovf_y;
  } ctx_t;

  typedef struct packed {
    logic signed [DW-1:0] accel;
    logic                 sat;
  } acc_res_t;

  function automatic logic [XW-1:0] mag(input logic signed [XW-1:0] v);
    mag = v[XW-1] ? XW'(-v) : XW'(v);
  endfunction

  // apply the sign and clamp to the output range; rounding is already applied
  function automatic acc_res_t finish(input logic [QW-1:0] q, input logic neg,
                                      input logic zero, input logic ovf);
    acc_res_t r;
    r.sat   = 1'b0;
    r.accel = '0;
    if (zero) begin
      r.accel = '0;
    end else if (ovf || (!neg && (q > POS_MAX)) || (neg && (q > NEG_MAX))) begin
      r.sat   = 1'b1;
      r.accel = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      r.accel = neg ? -$signed(q[DW-1:0]) : $signed(q[DW-1:0]);
    end
    return r;
  endfunction

  // configuration registers
  logic [RW-1:0] arrival_q, slowdown_q, top_q;
  logic [TW-1:0] reach_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrival_q  <= RW'(1280);
      slowdown_q <= RW'(25600);
      top_q      <= RW'(12800);
      reach_q    <= TW'(256);
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[3:2]))
        REG_ARRIVAL:  arrival_q  <= pwdata[RW-1:0];
        REG_SLOWDOWN: slowdown_q <= pwdata[RW-1:0];
        REG_TOP:      top_q      <= pwdata[RW-1:0];
        REG_REACH:    reach_q    <= pwdata[TW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_e'(paddr[3:2]))
      REG_ARRIVAL:  prdata = 32'(arrival_q);
      REG_SLOWDOWN: prdata = 32'(slowdown_q);
      REG_TOP:      prdata = 32'(top_q);
      REG_REACH:    prdata = 32'(reach_q);
    endcase
  end

  // pipeline advance: everything holds while the result is stalled
  logic valid_q[ST_OUT+1];
  logic en;

  assign en          = !(valid_q[ST_OUT] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = valid_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= ST_OUT; i++) valid_q[i] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid_i;
      for (int i = 1; i <= ST_OUT; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  // datapath signals
  ctx_t               ctx_q[ST_OUT+1];
  ctx_t               ctx_d[ST_OUT+1];
  logic [2*XW-1:0]    sx_q, sy_q, sum_q;
  logic [XW-1:0]      sq_root;
  logic [PW-1:0]      spd_num_d, spd_num_q;
  spd_sel_e           sel_w;
  logic [QW-1:0]      spd_quo;
  logic [RW-1:0]      speed_w;
  logic [PW-1:0]      gnum_x_d, gnum_y_d, gnum_x_q, gnum_y_q;
  logic [QW-1:0]      gquo_x, gquo_y;
  logic signed [XW-1:0] gx_w, gy_w, diff_x_w, diff_y_w;
  logic [AW-1:0]      anum_x_d, anum_y_d, anum_x_q, anum_y_q;
  logic [QW-1:0]      aquo_x, aquo_y;
  acc_res_t           res_x_w, res_y_w;
  logic signed [DW-1:0] ax_q, ay_q;
  logic               sat_q;

  // context line; each stage fills in what it learns
  always_comb begin
    for (int i = 0; i <= ST_OUT; i++) ctx_d[i] = (i == 0) ? ctx_q[0] : ctx_q[(i == 0) ? 0 : i - 1];

    ctx_d[ST_IN].dx = XW'(goal_pos_x_i) - XW'(char_pos_x_i);
    ctx_d[ST_IN].dy = XW'(goal_pos_y_i) - XW'(char_pos_y_i);
    ctx_d[ST_IN].dx = $signed({goal_pos_x_i[DW-1], goal_pos_x_i})
                    - $signed({char_pos_x_i[DW-1], char_pos_x_i});
    ctx_d[ST_IN].dy = $signed({goal_pos_y_i[DW-1], goal_pos_y_i})
                    - $signed({char_pos_y_i[DW-1], char_pos_y_i});
    ctx_d[ST_IN].vx = char_vel_x_i;
    ctx_d[ST_IN].vy = char_vel_y_i;

    ctx_d[ST_SPD].dlen = sq_root;
    ctx_d[ST_SPD].sel  = sel_w;

    ctx_d[ST_ACC].neg_x  = diff_x_w[XW-1];
    ctx_d[ST_ACC].neg_y  = diff_y_w[XW-1];
    ctx_d[ST_ACC].zero_x = (diff_x_w == '0);
    ctx_d[ST_ACC].zero_y = (diff_y_w == '0);
    ctx_d[ST_ACC].ovf_x  = TW'(anum_x_d[AW-1:QW]) >= reach_q;
    ctx_d[ST_ACC].ovf_y  = TW'(anum_y_d[AW-1:QW]) >= reach_q;
  end

  // squared length and its root
  asa_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q),
    .root_o (sq_root)
  );

  // speed selection and speed numerator
  always_comb begin
    if (sq_root < XW'(arrival_q)) begin
      sel_w = SPD_ZERO;
    end else if (sq_root > XW'(slowdown_q)) begin
      sel_w = SPD_TOP;
    end else if (slowdown_q == '0) begin
      sel_w = SPD_ZERO;
    end else begin
      sel_w = SPD_DIV;
    end
    spd_num_d = PW'(top_q) * PW'(sq_root) + PW'(slowdown_q >> 1);
  end

  asa_div u_div_spd (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (QW'(spd_num_q[PW-1:QW])),
    .num_i (spd_num_q[QW-1:0]),
    .den_i (QW'(slowdown_q)),
    .quo_o (spd_quo)
  );

  // goal velocity numerators
  always_comb begin
    case (ctx_q[ST_GOAL-1].sel)
      SPD_DIV: speed_w = spd_quo[RW-1:0];
      SPD_TOP: speed_w = top_q;
      default: speed_w = '0;
    endcase
    gnum_x_d = PW'(mag(ctx_q[ST_GOAL-1].dx)) * PW'(speed_w)
             + PW'(ctx_q[ST_GOAL-1].dlen >> 1);
    gnum_y_d = PW'(mag(ctx_q[ST_GOAL-1].dy)) * PW'(speed_w)
             + PW'(ctx_q[ST_GOAL-1].dlen >> 1);
  end

  asa_div u_div_gx (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (QW'(gnum_x_q[PW-1:QW])),
    .num_i (gnum_x_q[QW-1:0]),
    .den_i (ctx_q[ST_GOAL].dlen),
    .quo_o (gquo_x)
  );

  asa_div u_div_gy (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (QW'(gnum_y_q[PW-1:QW])),
    .num_i (gnum_y_q[QW-1:0]),
    .den_i (ctx_q[ST_GOAL].dlen),
    .quo_o (gquo_y)
  );

  // velocity difference and acceleration numerators
  always_comb begin
    logic [XW-1:0] gmx, gmy;
    gmx = (ctx_q[ST_ACC-1].dlen == '0) ? '0 : XW'(gquo_x[RW-1:0]);
    gmy = (ctx_q[ST_ACC-1].dlen == '0) ? '0 : XW'(gquo_y[RW-1:0]);
    gx_w = ctx_q[ST_ACC-1].dx[XW-1] ? -$signed(gmx) : $signed(gmx);
    gy_w = ctx_q[ST_ACC-1].dy[XW-1] ? -$signed(gmy) : $signed(gmy);
    diff_x_w = gx_w - $signed({ctx_q[ST_ACC-1].vx[DW-1], ctx_q[ST_ACC-1].vx});
    diff_y_w = gy_w - $signed({ctx_q[ST_ACC-1].vy[DW-1], ctx_q[ST_ACC-1].vy});
    anum_x_d = {mag(diff_x_w), 8'h00} + AW'(reach_q >> 1);
    anum_y_d = {mag(diff_y_w), 8'h00} + AW'(reach_q >> 1);
  end

  asa_div u_div_ax (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (QW'(anum_x_q[AW-1:QW])),
    .num_i (anum_x_q[QW-1:0]),
    .den_i (QW'(reach_q)),
    .quo_o (aquo_x)
  );

  asa_div u_div_ay (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (QW'(anum_y_q[AW-1:QW])),
    .num_i (anum_y_q[QW-1:0]),
    .den_i (QW'(reach_q)),
    .quo_o (aquo_y)
  );

  // sign and clamp
  assign res_x_w = finish(aquo_x, ctx_q[ST_OUT-1].neg_x, ctx_q[ST_OUT-1].zero_x,
                          ctx_q[ST_OUT-1].ovf_x);
  assign res_y_w = finish(aquo_y, ctx_q[ST_OUT-1].neg_y, ctx_q[ST_OUT-1].zero_y,
                          ctx_q[ST_OUT-1].ovf_y);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i <= ST_OUT; i++) ctx_q[i] <= ctx_d[i];
      sx_q      <= mag(ctx_q[ST_SQR-1].dx) * mag(ctx_q[ST_SQR-1].dx);
      sy_q      <= mag(ctx_q[ST_SQR-1].dy) * mag(ctx_q[ST_SQR-1].dy);
      sum_q     <= sx_q + sy_q;
      spd_num_q <= spd_num_d;
      gnum_x_q  <= gnum_x_d;
      gnum_y_q  <= gnum_y_d;
      anum_x_q  <= anum_x_d;
      anum_y_q  <= anum_y_d;
      ax_q      <= res_x_w.accel;
      ay_q      <= res_y_w.accel;
      sat_q     <= res_x_w.sat || res_y_w.sat;
    end
  end

  assign accel_x_o   = ax_q;
  assign accel_y_o   = ay_q;
  assign saturated_o = sat_q;

endmodule

FILE: rtl/asa_checker.sv
// Port-level checks for arrive_steering_accel, bound to the top level.
// Depends on asa_pkg for the data width.
`timescale 1ns / 1ps

module asa_port_checks (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [asa_pkg::DATA_W-1:0] accel_x_o,
  input logic signed [asa_pkg::DATA_W-1:0] accel_y_o,
  input logic                              saturated_o
);

  localparam logic signed [asa_pkg::DATA_W-1:0] A_MAX = {1'b0, {(asa_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [asa_pkg::DATA_W-1:0] A_MIN = {1'b1, {(asa_pkg::DATA_W-1){1'b0}}};

  // a stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(accel_x_o) && $stable(accel_y_o)
                                    && $stable(saturated_o))
    else $error("stalled result changed");

  // the input only stalls behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // a clamped item shows an extreme value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> accel_x_o == A_MAX || accel_x_o == A_MIN
                                   || accel_y_o == A_MAX || accel_y_o == A_MIN)
    else $error("saturated flag without a clamped component");

endmodule

bind arrive_steering_accel asa_port_checks u_asa_port_checks (.*);
